// ===== sv/crss_pkg.sv =====
// Shared types and constants of the chunked render stage sequencer.
package crss_pkg;

    localparam int CHUNK_MAX   = 32;
    localparam int SUBTILES    = 16;
    localparam int SUM_MAX     = 1023;
    localparam int LINE_SH_MAX = 12;

    // Input operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ENTRY = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_FETCH  = 2'd2;
    localparam logic [1:0] KIND_STORE  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_CHUNK_SIZE  = 3'd0;
    localparam logic [2:0] REG_ORDER_BYTES = 3'd1;
    localparam logic [2:0] REG_PROJ_BASE   = 3'd2;
    localparam logic [2:0] REG_PROJ_BYTES  = 3'd3;
    localparam logic [2:0] REG_LINE_LOG2   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [1:0] kind;
        logic       last;
        logic       fetch_next;
    } crss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       plan_store;
        logic       plan_load;
        logic [5:0] fetch_cnt;
        logic [4:0] fetch_idx;
        logic       out_free;
    } crss_stat_t;

endpackage

// ===== sv/chunked_render_stage_sequencer.sv =====
// Top level of the chunked render stage sequencer.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    tuser operation, tdata item fields
//  m_       out        m_tvalid/m_tready    tuser kind, tdata request, tlast
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time: s_tready returns the cycle after the last result enters the
// output register. A decide state follows the accept; a status, load or store
// result is then emitted from its own state and each projection address passes
// through buffer read, multiply, and add and align states. Reset is synchronous,
// active low. A stall on m_ holds the sequencer until the pending transaction is
// taken.
module chunked_render_stage_sequencer import crss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // tile_base, entry_count, gaussian_index,
                                   // subtile_count, order_load_done,
                                   // feature_load_done, order_store_done
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // address, byte_length, finished, 2 zero bits
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    crss_cmd_t  cmd;
    crss_stat_t stat;

    assign cfg_ready = 1'b1;

    crss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crss_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sv/crss_ctrl.sv =====
// Controller state machine: accepts one item and sequences its results.
module crss_ctrl import crss_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  crss_stat_t stat,
    output crss_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_STORE  = 3'd2;
    localparam logic [2:0] ST_FRD    = 3'd3;
    localparam logic [2:0] ST_FMUL   = 3'd4;
    localparam logic [2:0] ST_FOUT   = 3'd5;
    localparam logic [2:0] ST_LOAD   = 3'd6;
    localparam logic [2:0] ST_STAT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       fetch_final;

    assign s_tready    = (state_reg == ST_IDLE);
    assign fetch_final = ({1'b0, stat.fetch_idx} + 6'd1) == stat.fetch_cnt;

    // Step through store, fetch addresses, load, or a lone status result
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.plan_store)
                    state_next = ST_STORE;
                else if (stat.fetch_cnt != 6'd0)
                    state_next = ST_FRD;
                else if (stat.plan_load)
                    state_next = ST_LOAD;
                else
                    state_next = ST_STAT;
            end
            ST_STORE: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_STORE;
                    cmd.last = (stat.fetch_cnt == 6'd0) && !stat.plan_load;
                    if (stat.fetch_cnt != 6'd0)
                        state_next = ST_FRD;
                    else if (stat.plan_load)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FRD:  state_next = ST_FMUL;
            ST_FMUL: state_next = ST_FOUT;
            ST_FOUT: begin
                if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = KIND_FETCH;
                    cmd.last       = fetch_final && !stat.plan_load;
                    cmd.fetch_next = 1'b1;
                    if (!fetch_final)
                        state_next = ST_FRD;
                    else if (stat.plan_load)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_LOAD;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_STAT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_STATUS;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/crss_dp.sv =====
// Datapath: configuration, stage state, entry buffer, address math, output register.
module crss_dp import crss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic [1:0]  s_tuser,
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  crss_cmd_t   cmd,
    output crss_stat_t  stat
);

    // Input fields
    logic [39:0] in_base;
    logic [15:0] in_count;
    logic [31:0] in_index;
    logic [4:0]  in_sub;
    logic        in_lok, in_fok, in_sok;
    assign in_base  = s_tdata[39:0];
    assign in_count = s_tdata[55:40];
    assign in_index = s_tdata[87:56];
    assign in_sub   = s_tdata[92:88];
    assign in_lok   = s_tdata[93];
    assign in_fok   = s_tdata[94];
    assign in_sok   = s_tdata[95];

    // Configuration
    logic [5:0]  chunk_reg;
    logic [7:0]  oeb_reg;
    logic [39:0] pbase_reg;
    logic [9:0]  peb_reg;
    logic [3:0]  lsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= 6'd32;
            oeb_reg   <= 8'd8;
            pbase_reg <= '0;
            peb_reg   <= 10'd64;
            lsh_reg   <= 4'd6;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CHUNK_SIZE:  chunk_reg <= cfg_data[5:0];
                REG_ORDER_BYTES: oeb_reg   <= cfg_data[7:0];
                REG_PROJ_BASE:   pbase_reg <= cfg_data;
                REG_PROJ_BYTES:  peb_reg   <= cfg_data[9:0];
                REG_LINE_LOG2:   lsh_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Architectural state
    logic        running_reg, running_next;
    logic        sp_reg, sp_next;
    logic [39:0] taddr_reg, taddr_next;
    logic [15:0] tent_reg, tent_next;
    logic [15:0] nls_reg, nls_next;
    logic [3:0]  sv_reg, sv_next;
    logic [5:0]  sc0_reg, sc1_reg, sc2_reg, sc3_reg;
    logic [5:0]  sc0_next, sc1_next, sc2_next, sc3_next;
    logic [9:0]  rcl_reg, rcl_next;
    logic [9:0]  sum0_reg, sum1_reg, sum0_next, sum1_next;
    logic [5:0]  fill_reg, fill_next;
    logic        lok_reg, fok_reg, sok_reg, lok_next, fok_next, sok_next;

    // Plan for the current item
    logic        pstore_reg, pstore_next, pload_reg, pload_next;
    logic [5:0]  fcnt_reg, fcnt_next;
    logic [12:0] llen_reg, llen_next;
    logic [4:0]  fidx_reg;

    // Entry buffer
    logic [31:0] ebuf_mem [CHUNK_MAX];
    logic        ebuf_we;
    logic [31:0] rdata_reg;
    logic [41:0] prod_reg;

    // Helpers
    logic [5:0]  eff_chunk;
    logic [15:0] load_base, rem;
    logic [5:0]  load_cnt;
    logic        do_load, run_done;
    logic [9:0]  rcl_dec;
    logic [4:0]  sub_cap;
    logic [10:0] sum_add;

    always_comb begin
        if (chunk_reg == 6'd0)
            eff_chunk = 6'd1;
        else if (chunk_reg > 6'(CHUNK_MAX))
            eff_chunk = 6'(CHUNK_MAX);
        else
            eff_chunk = chunk_reg;
    end

    assign rcl_dec = (rcl_reg != 10'd0) ? rcl_reg - 10'd1 : 10'd0;
    assign sub_cap = (in_sub > 5'(SUBTILES)) ? 5'(SUBTILES) : in_sub;
    assign sum_add = {1'b0, sum0_reg} + {6'd0, sub_cap};
    assign ebuf_we = cmd.accept && (s_tuser == OP_ENTRY) && sv_reg[0]
                     && (fill_reg < sc0_reg);

    // Apply one accepted item to the stage state and plan its results
    always_comb begin
        running_next = running_reg;
        sp_next      = sp_reg;
        taddr_next   = taddr_reg;
        tent_next    = tent_reg;
        nls_next     = nls_reg;
        sv_next      = sv_reg;
        sc0_next     = sc0_reg;
        sc1_next     = sc1_reg;
        sc2_next     = sc2_reg;
        sc3_next     = sc3_reg;
        rcl_next     = rcl_reg;
        sum0_next    = sum0_reg;
        sum1_next    = sum1_reg;
        fill_next    = fill_reg;
        lok_next     = lok_reg;
        fok_next     = fok_reg;
        sok_next     = sok_reg;
        pstore_next  = 1'b0;
        pload_next   = 1'b0;
        fcnt_next    = 6'd0;
        llen_next    = llen_reg;
        do_load      = 1'b0;
        load_base    = nls_reg;
        run_done     = 1'b0;

        if (s_tuser == OP_TICK) begin
            rcl_next = rcl_dec;
            lok_next = lok_reg | in_lok;
            fok_next = fok_reg | in_fok;
            sok_next = sok_reg | in_sok;
            if (!running_reg) begin
                if (sp_reg) begin
                    sp_next = 1'b0;
                    if (tent_reg != 16'd0) begin
                        running_next = 1'b1;
                        load_base    = 16'd0;
                        do_load      = 1'b1;
                    end
                end
            end else begin
                run_done = !(sv_reg[0] && !lok_next) && !(sv_reg[1] && !fok_next)
                           && !(sv_reg[2] && (rcl_dec != 10'd0))
                           && !(sv_reg[3] && !sok_next);
                if (run_done) begin
                    if (sv_reg == 4'd0) begin
                        running_next = 1'b0;
                    end else begin
                        sv_next = {sv_reg[2:0], 1'b0};
                        if (sv_reg[2]) begin
                            sc3_next    = sc2_reg;
                            sok_next    = 1'b0;
                            pstore_next = 1'b1;
                        end
                        if (sv_reg[1]) begin
                            sc2_next = sc1_reg;
                            rcl_next = sum1_reg;
                        end
                        if (sv_reg[0]) begin
                            sc1_next  = sc0_reg;
                            sum1_next = sum0_reg;
                            fok_next  = 1'b0;
                            fcnt_next = sc0_reg;
                        end
                        do_load = nls_reg < tent_reg;
                    end
                end
            end
        end else if (s_tuser == OP_START) begin
            taddr_next = in_base;
            tent_next  = in_count;
            sp_next    = 1'b1;
        end else if (s_tuser == OP_ENTRY) begin
            if (ebuf_we) begin
                fill_next = fill_reg + 6'd1;
                sum0_next = (sum_add > 11'(SUM_MAX)) ? 10'(SUM_MAX) : sum_add[9:0];
            end
        end

        rem      = tent_reg - load_base;
        load_cnt = (rem < {10'd0, eff_chunk}) ? rem[5:0] : eff_chunk;
        if (do_load) begin
            sv_next[0] = 1'b1;
            sc0_next   = load_cnt;
            lok_next   = 1'b0;
            fill_next  = 6'd0;
            sum0_next  = 10'd0;
            nls_next   = load_base + {10'd0, load_cnt};
            pload_next = 1'b1;
            llen_next  = 13'(load_cnt * oeb_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            sp_reg      <= 1'b0;
            taddr_reg   <= '0;
            tent_reg    <= '0;
            nls_reg     <= '0;
            sv_reg      <= '0;
            sc0_reg     <= '0;
            sc1_reg     <= '0;
            sc2_reg     <= '0;
            sc3_reg     <= '0;
            rcl_reg     <= '0;
            sum0_reg    <= '0;
            sum1_reg    <= '0;
            fill_reg    <= '0;
            lok_reg     <= 1'b0;
            fok_reg     <= 1'b0;
            sok_reg     <= 1'b0;
            pstore_reg  <= 1'b0;
            pload_reg   <= 1'b0;
            fcnt_reg    <= '0;
            fidx_reg    <= '0;
        end else begin
            if (cmd.accept) begin
                running_reg <= running_next;
                sp_reg      <= sp_next;
                taddr_reg   <= taddr_next;
                tent_reg    <= tent_next;
                nls_reg     <= nls_next;
                sv_reg      <= sv_next;
                sc0_reg     <= sc0_next;
                sc1_reg     <= sc1_next;
                sc2_reg     <= sc2_next;
                sc3_reg     <= sc3_next;
                rcl_reg     <= rcl_next;
                sum0_reg    <= sum0_next;
                sum1_reg    <= sum1_next;
                fill_reg    <= fill_next;
                lok_reg     <= lok_next;
                fok_reg     <= fok_next;
                sok_reg     <= sok_next;
                pstore_reg  <= pstore_next;
                pload_reg   <= pload_next;
                fcnt_reg    <= fcnt_next;
                fidx_reg    <= '0;
            end else if (cmd.fetch_next) begin
                fidx_reg <= fidx_reg + 5'd1;
            end
        end
    end

    // Load request length
    always_ff @(posedge aclk) begin
        if (cmd.accept)
            llen_reg <= llen_next;
    end

    // Write entries, read one per fetch step, then scale by record size
    always_ff @(posedge aclk) begin
        if (ebuf_we)
            ebuf_mem[fill_reg[4:0]] <= in_index;
        rdata_reg <= ebuf_mem[fidx_reg];
        prod_reg  <= rdata_reg * peb_reg;
    end

    // Aligned projection address
    logic [3:0]  lsh_eff;
    logic [39:0] fetch_sum, fetch_addr;
    assign lsh_eff    = (lsh_reg > 4'(LINE_SH_MAX)) ? 4'(LINE_SH_MAX) : lsh_reg;
    assign fetch_sum  = pbase_reg + prod_reg[39:0];
    assign fetch_addr = fetch_sum & ~((40'd1 << lsh_eff) - 40'd1);

    // Output register
    logic        mvalid_reg;
    logic [1:0]  mkind_reg;
    logic        mlast_reg, mfin_reg;
    logic [39:0] maddr_reg;
    logic [12:0] mlen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            mvalid_reg <= 1'b0;
        else if (cmd.emit)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            mkind_reg <= cmd.kind;
            mlast_reg <= cmd.last;
            mfin_reg  <= !running_reg && !sp_reg;
            case (cmd.kind)
                KIND_STORE: begin
                    maddr_reg <= taddr_reg;
                    mlen_reg  <= 13'(sc3_reg * oeb_reg);
                end
                KIND_LOAD: begin
                    maddr_reg <= taddr_reg;
                    mlen_reg  <= llen_reg;
                end
                KIND_FETCH: begin
                    maddr_reg <= fetch_addr;
                    mlen_reg  <= '0;
                end
                default: begin
                    maddr_reg <= '0;
                    mlen_reg  <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {2'b00, mfin_reg, mlen_reg, maddr_reg};

    assign stat.plan_store = pstore_reg;
    assign stat.plan_load  = pload_reg;
    assign stat.fetch_cnt  = fcnt_reg;
    assign stat.fetch_idx  = fidx_reg;
    assign stat.out_free   = !mvalid_reg || m_tready;

endmodule

// ===== sv/crss_checker.sv =====
// Port-level checks of the sequencer, bound to the top level.
module crss_checker import crss_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Block input for the cycle after an accepted transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Status results carry no request and close their item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast && (m_tdata[52:0] == 53'd0))
        else $error("bad status result");

    // Projection addresses carry no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_FETCH) |-> (m_tdata[52:40] == 13'd0))
        else $error("fetch with length");

endmodule

bind chunked_render_stage_sequencer crss_checker u_crss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/testbench.sv =====
// Self-checking testbench of the chunked render stage sequencer.
module testbench import crss_pkg::*;;

    // One input item, fields as in s_tdata plus the operation
    typedef struct packed {
        logic [1:0]  op;
        logic [39:0] base;
        logic [15:0] cnt;
        logic [31:0] gidx;
        logic [4:0]  sub;
        logic        ld;
        logic        fd;
        logic        sd;
    } tile_item_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [39:0] addr;
        logic [12:0] len;
        logic        last;
        logic        fin;
    } mem_req_t;

    // Sequencer state and its register copy
    typedef struct {
        bit          running;
        bit          pend;
        bit [39:0]   taddr;
        bit [15:0]   tent;
        bit [15:0]   nls;
        bit [3:0]    busy;
        int unsigned scnt[4];
        int unsigned rcl;
        int unsigned sum[2];
        bit [31:0]   ent_idx[32];
        bit [31:0]   written;
        int unsigned fill;
        bit          lok, fok, sok;
        bit [5:0]    chunk;
        bit [7:0]    oeb;
        bit [39:0]   pbase;
        bit [9:0]    peb;
        bit [3:0]    lsh;
    } seq_state_t;

    // Operation code that the block ignores
    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [39:0] cfg_data;

    chunked_render_stage_sequencer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    seq_state_t   live_st;   // advanced on accepted transactions
    seq_state_t   plan_st;   // advanced while the stimulus is planned
    tile_item_t   pending_items[$];
    tile_item_t   cur_item;
    mem_req_t     expected_reqs[$];
    int           errors = 0;
    int           planned = 0;
    int           idle_cycles = 0;
    bit           long_hold_req = 0;
    bit           quiet_mode = 0;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic void state_reset(inout seq_state_t s);
        s.running = 0; s.pend = 0; s.taddr = 0; s.tent = 0; s.nls = 0; s.busy = 0;
        for (int i = 0; i < 4; i++) s.scnt[i] = 0;
        s.rcl = 0; s.sum[0] = 0; s.sum[1] = 0;
        for (int i = 0; i < 32; i++) s.ent_idx[i] = 0;
        s.written = 0; s.fill = 0; s.lok = 0; s.fok = 0; s.sok = 0;
        s.chunk = 32; s.oeb = 8; s.pbase = 0; s.peb = 64; s.lsh = 6;
    endfunction

    function automatic void reg_write(inout seq_state_t s, input logic [2:0] idx,
                                      input logic [39:0] val);
        case (idx)
            REG_CHUNK_SIZE:  s.chunk = val[5:0];
            REG_ORDER_BYTES: s.oeb = val[7:0];
            REG_PROJ_BASE:   s.pbase = val;
            REG_PROJ_BYTES:  s.peb = val[9:0];
            REG_LINE_LOG2:   s.lsh = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic void add_req(ref mem_req_t q[$], input logic [1:0] kind,
                                    input logic [39:0] addr, input int unsigned len);
        mem_req_t r;
        r.kind = kind; r.addr = addr; r.len = len[12:0]; r.last = 0; r.fin = 0;
        q.insert(q.size(), r);
    endfunction

    // Issue the next order load of min(chunk, remaining) entries
    function automatic void start_load(inout seq_state_t s, ref mem_req_t q[$]);
        int unsigned rem, cnt;
        rem = s.tent - s.nls;
        cnt = (s.chunk == 0) ? 1 : (s.chunk > CHUNK_MAX ? CHUNK_MAX : s.chunk);
        if (rem < cnt) cnt = rem;
        s.scnt[0] = cnt; s.busy[0] = 1; s.lok = 0; s.fill = 0; s.sum[0] = 0;
        s.nls = s.nls + cnt;
        add_req(q, KIND_LOAD, s.taddr, cnt * s.oeb);
    endfunction

    // Advance all chunks one stage once every busy stage is done
    function automatic void advance_stages(inout seq_state_t s, ref mem_req_t q[$]);
        bit [63:0] a;
        int unsigned sh;
        if ((s.busy[0] && !s.lok) || (s.busy[1] && !s.fok) ||
            (s.busy[2] && s.rcl > 0) || (s.busy[3] && !s.sok)) return;
        if (s.busy == 0) begin
            s.running = 0;
            return;
        end
        s.busy[3] = 0;
        if (s.busy[2]) begin
            s.busy[2] = 0; s.busy[3] = 1; s.scnt[3] = s.scnt[2]; s.sok = 0;
            add_req(q, KIND_STORE, s.taddr, s.scnt[3] * s.oeb);
        end
        if (s.busy[1]) begin
            s.busy[1] = 0; s.busy[2] = 1; s.scnt[2] = s.scnt[1]; s.rcl = s.sum[1];
        end
        if (s.busy[0]) begin
            s.busy[0] = 0; s.busy[1] = 1; s.scnt[1] = s.scnt[0]; s.sum[1] = s.sum[0];
            s.fok = 0;
            sh = (s.lsh > LINE_SH_MAX) ? LINE_SH_MAX : s.lsh;
            for (int i = 0; i < s.scnt[1] && i < CHUNK_MAX; i++) begin
                a = (64'(s.pbase) + 64'(s.ent_idx[i]) * 64'(s.peb)) & 64'hFF_FFFF_FFFF;
                a = a & ~((64'd1 << sh) - 64'd1);
                add_req(q, KIND_FETCH, a[39:0], 0);
            end
        end
        if (s.nls < s.tent) start_load(s, q);
    endfunction

    // Work out the results of one input item
    function automatic void predict_item(inout seq_state_t s, input tile_item_t it,
                                         ref mem_req_t q[$]);
        mem_req_t res[$];
        int unsigned sc;
        case (it.op)
            OP_TICK: begin
                if (s.rcl > 0) s.rcl--;
                if (it.ld) s.lok = 1;
                if (it.fd) s.fok = 1;
                if (it.sd) s.sok = 1;
                if (!s.running) begin
                    if (s.pend) begin
                        s.pend = 0;
                        if (s.tent != 0) begin
                            s.running = 1; s.nls = 0;
                            start_load(s, res);
                        end
                    end
                end else begin
                    advance_stages(s, res);
                end
            end
            OP_START: begin
                s.taddr = it.base; s.tent = it.cnt; s.pend = 1;
            end
            OP_ENTRY: begin
                if (s.busy[0] && s.fill < s.scnt[0] && s.fill < CHUNK_MAX) begin
                    sc = (it.sub > SUBTILES) ? SUBTILES : it.sub;
                    s.ent_idx[s.fill] = it.gidx;
                    s.written[s.fill] = 1;
                    s.fill++;
                    s.sum[0] += sc;
                    if (s.sum[0] > SUM_MAX) s.sum[0] = SUM_MAX;
                end
            end
            default: ;
        endcase
        if (res.size() == 0) add_req(res, KIND_STATUS, 0, 0);
        foreach (res[i]) res[i].fin = !s.running && !s.pend;
        res[res.size() - 1].last = 1;
        foreach (res[i]) q.insert(q.size(), res[i]);
    endfunction

    // Queue an item, tracking the planned state to shape later items
    task automatic plan_item(input tile_item_t it);
        mem_req_t dummy[$];
        predict_item(plan_st, it, dummy);
        pending_items.insert(pending_items.size(), it);
        if (it.op != OP_IGNORED) planned++;
    endtask

    function automatic tile_item_t mk_item(input logic [1:0] op);
        tile_item_t it;
        it = '0;
        it.op = op;
        return it;
    endfunction

    task automatic plan_start(input logic [39:0] base, input logic [15:0] cnt);
        tile_item_t it;
        it = mk_item(OP_START);
        it.base = base; it.cnt = cnt;
        plan_item(it);
    endtask

    task automatic plan_entry(input logic [31:0] gidx, input logic [4:0] sub);
        tile_item_t it;
        it = mk_item(OP_ENTRY);
        it.gidx = gidx; it.sub = sub;
        plan_item(it);
    endtask

    task automatic plan_tick(input bit ld, input bit fd, input bit sd);
        tile_item_t it;
        it = mk_item(OP_TICK);
        it.ld = ld; it.fd = fd; it.sd = sd;
        plan_item(it);
    endtask

    function automatic logic [4:0] rand_sub();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 5'($urandom_range(0, 2));
        if (r < 95) return 5'($urandom_range(0, 16));
        return 5'($urandom_range(17, 31));
    endfunction

    // Feed well-formed traffic, with some noise, until the tile finishes
    task automatic run_tile();
        int guard;
        int r;
        bit ld, early_ok;
        guard = 0;
        while ((plan_st.running || plan_st.pend) && guard < 4000) begin
            guard++;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                plan_item(mk_item(OP_IGNORED));
            end else if (r < 4) begin
                plan_entry({$urandom}, rand_sub());
            end else if (r < 5) begin
                plan_start(40'({$urandom, $urandom}), 16'($urandom_range(0, 5)));
            end else if (plan_st.busy[0] && plan_st.fill < plan_st.scnt[0] && r < 80) begin
                plan_entry({$urandom}, rand_sub());
            end else begin
                early_ok = 1;
                for (int i = 0; i < plan_st.scnt[0]; i++)
                    if (!plan_st.written[i]) early_ok = 0;
                if (plan_st.busy[0] && !plan_st.lok) begin
                    if (plan_st.fill >= plan_st.scnt[0]) ld = ($urandom_range(0, 1) == 1);
                    else ld = early_ok && ($urandom_range(0, 19) == 0);
                end else begin
                    ld = ($urandom_range(0, 4) == 0) && (!plan_st.busy[0] || early_ok);
                end
                plan_tick(ld, $urandom_range(0, 4) < 2, $urandom_range(0, 4) < 2);
            end
        end
    endtask

    // Write one register and track it in both state copies
    task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        reg_write(live_st, idx, val);
        reg_write(plan_st, idx, val);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_reqs.size() != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // Stimulus: directed start, then random tiles over several settings
    initial begin
        state_reset(live_st);
        state_reset(plan_st);
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // idle tick, ignored operation, stray entry, empty tile
        plan_tick(0, 0, 0);
        plan_item(mk_item(OP_IGNORED));
        plan_entry(32'hFFFF_FFFF, 5'd31);
        plan_start(40'h0, 16'h0);
        plan_tick(1, 1, 1);
        // huge count overwritten before it is taken
        plan_start(40'hFF_FFFF_FFFF, 16'hFFFF);
        plan_start(40'hFF_FFFF_FFC0, 16'd3);
        plan_tick(1, 1, 1);
        plan_entry(32'hFFFF_FFFF, 5'd31);
        plan_entry(32'h0, 5'd0);
        plan_entry(32'h5, 5'd16);
        plan_entry(32'h7, 5'd16);
        run_tile();
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_CHUNK_SIZE, 40'd1);
                    write_reg(REG_ORDER_BYTES, 40'd255);
                    write_reg(REG_PROJ_BASE, 40'hFF_FFFF_FFFF);
                    write_reg(REG_PROJ_BYTES, 40'd1023);
                    write_reg(REG_LINE_LOG2, 40'd12);
                end
                1: begin
                    write_reg(REG_CHUNK_SIZE, 40'd0);
                    write_reg(REG_ORDER_BYTES, 40'd1);
                    write_reg(REG_PROJ_BASE, 40'h0);
                    write_reg(REG_PROJ_BYTES, 40'd1);
                    write_reg(REG_LINE_LOG2, 40'd0);
                end
                2: begin
                    write_reg(REG_CHUNK_SIZE, 40'd63);
                    write_reg(REG_ORDER_BYTES, 40'd0);
                    write_reg(REG_PROJ_BYTES, 40'd0);
                    write_reg(REG_LINE_LOG2, 40'd15);
                    long_hold_req = 1;
                end
                3: begin
                    write_reg(REG_CHUNK_SIZE, 40'($urandom_range(2, 31)));
                    write_reg(REG_ORDER_BYTES, 40'($urandom_range(1, 255)));
                    write_reg(REG_PROJ_BASE, 40'({$urandom, $urandom}));
                    write_reg(REG_PROJ_BYTES, 40'($urandom_range(1, 1023)));
                    write_reg(REG_LINE_LOG2, 40'($urandom_range(0, 12)));
                end
                default: begin
                    write_reg(REG_CHUNK_SIZE, 40'd32);
                    write_reg(REG_ORDER_BYTES, 40'd8);
                    write_reg(REG_PROJ_BASE, 40'h12_3456_7890);
                    write_reg(REG_PROJ_BYTES, 40'd64);
                    write_reg(REG_LINE_LOG2, 40'd6);
                end
            endcase
            cfg_valid <= 0;
            while (planned < 25 + (ph + 1) * 90) begin
                plan_start(40'({$urandom, $urandom}),
                           ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 70)));
                if ($urandom_range(0, 3) == 0) plan_tick(0, 0, 0);
                run_tile();
            end
            drain();
        end

        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    // Drive input transactions from the pending queue
    int send_gap = 0;
    always @(posedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) predict_item(live_st, cur_item, expected_reqs);
            if (s_tvalid && s_tready || !s_tvalid) begin
                nv = 0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    nv = 1;
                    if ($urandom_range(0, 199) == 0) quiet_mode = !quiet_mode;
                    if (!quiet_mode) begin
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5:  send_gap = $urandom_range(1, 3);
                            6:                 send_gap = $urandom_range(10, 40);
                            default:           send_gap = 0;
                        endcase
                    end
                end
                s_tvalid <= nv;
                s_tuser  <= cur_item.op;
                s_tdata  <= {cur_item.sd, cur_item.fd, cur_item.ld, cur_item.sub,
                             cur_item.gidx, cur_item.cnt, cur_item.base};
            end
        end
    end

    // Throttle the result side; hold off once for a long stretch
    int hold_cycles = 0;
    initial m_tready = 0;
    always @(posedge aclk) begin
        if (long_hold_req && s_tvalid) begin
            long_hold_req <= 0;
            hold_cycles <= 400;
            m_tready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else if (quiet_mode) begin
            m_tready <= 1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    hold_cycles <= $urandom_range(1, 3);
                    m_tready <= 0;
                end
                4: begin
                    hold_cycles <= $urandom_range(10, 40);
                    m_tready <= 0;
                end
                default: m_tready <= 1;
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        mem_req_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reqs.size() == 0) begin
                $error("unexpected result kind=%0d address=%h", m_tuser, m_tdata[39:0]);
                errors++;
            end else begin
                e = expected_reqs.pop_front();
                if (m_tuser !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[39:0] !== e.addr) begin
                    $error("address: expected %h, got %h", e.addr, m_tdata[39:0]);
                    errors++;
                end
                if (m_tdata[52:40] !== e.len) begin
                    $error("byte_length: expected %0d, got %0d", e.len, m_tdata[52:40]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    errors++;
                end
                if (m_tdata[53] !== e.fin) begin
                    $error("finished: expected %0d, got %0d", e.fin, m_tdata[53]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (s_tvalid && s_tready || m_tvalid && m_tready || cfg_valid && cfg_ready ||
            !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
